// File: design/sparse_table_range_extreme_macros.svh
// assertion macros for the sparse table range extreme block
`ifndef SPARSE_TABLE_RANGE_EXTREME_MACROS_SVH
`define SPARSE_TABLE_RANGE_EXTREME_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define STRE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/stre_pkg.sv
// types, constants and helpers for the sparse table range extreme block
package stre_pkg;

	localparam int unsigned MAX_ELEMENTS = 1024;
	localparam int unsigned LEVEL_COUNT  = 11;
	localparam int unsigned VALUE_W      = 32;
	localparam int unsigned FIELD_W      = 11;
	localparam int unsigned POS_W        = $clog2(MAX_ELEMENTS);
	localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned LVL_W        = $clog2(LEVEL_COUNT);
	localparam int unsigned LVC_W        = $clog2(LEVEL_COUNT + 1);
	localparam int unsigned CMP_W        = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic CFG_MODE  = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_BUILT = 2'd1;
	localparam logic [1:0] STATUS_BAD   = 2'd2;

	typedef struct packed {
		logic [1:0]               operation;
		logic [FIELD_W-1:0]       position;
		logic signed [31:0]       element_value;
		logic [FIELD_W-1:0]       left_bound;
		logic [FIELD_W-1:0]       right_bound;
	} item_t;

	typedef struct packed {
		logic signed [31:0] answer;
		logic [1:0]         status;
	} result_t;

	// max when mode is set, min otherwise
	function automatic logic signed [VALUE_W-1:0] pick(
		input logic mode,
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b
	);
		logic a_wins;
		a_wins = mode ? (a > b) : (a < b);
		return a_wins ? a : b;
	endfunction

endpackage

// File: design/sparse_table_range_extreme.sv
// sparse table range minimum / maximum: level memory, build sequencer, query path
//
// Usage: raise start with an item on item while busy is low; the item is
// taken at that edge. Operations:
//   load  - writes one element into level zero in the same edge (position
//           in 1..n), no result, busy stays low, so loads can go every cycle.
//   build - walks every level by doubling, one entry per cycle, with an
//           idle ST_BRUN beat and ST_BNEXT between levels, then one result
//           with status build done.
//   query - two table reads in the same cycle from the dual-read level memory,
//           then one compare; the result is registered in ST_QCMP and strobes
//           as the block returns to idle; a new item is taken at the end of that
//           strobe cycle. A bad range answers from ST_QADDR, skipping ST_QCMP.
// Results show on result for exactly one cycle with strobe high; the
// receiver cannot stall them. The user must write configuration (mode, element
// count) on the always-ready cfg channel only while idle, unchecked by the block.
// Reset clears the sequencer, strobe, mode (minimum) and count (one); the
// table memory is not cleared and must be loaded before use.
module sparse_table_range_extreme
	import stre_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  item_t               item,
	output logic                strobe,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [FIELD_W-1:0]  cfg_data
);

`include "sparse_table_range_extreme_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QADDR,
		ST_QCMP,
		ST_BRUN,
		ST_BNEXT
	} state_t;

	state_t state_q;

	logic               mode_q;
	logic [FIELD_W-1:0] count_q;

	logic signed [VALUE_W-1:0] mem [LEVEL_COUNT][MAX_ELEMENTS];
	logic signed [VALUE_W-1:0] rd_a_q, rd_b_q;

	logic [LVL_W-1:0] ra_lvl, rb_lvl, wr_lvl;
	logic [POS_W-1:0] ra_idx, rb_idx, wr_idx;
	logic signed [VALUE_W-1:0] wr_data;
	logic             wr_en;

	logic [CMP_W-1:0] cnt_ext, n_ext, pos_ext, l_ext, r_ext;
	logic             accept, load_we, bad_in;

	logic             bad_q;
	logic [CNT_W-1:0] len_q, r_q;
	logic [POS_W-1:0] lm1_q;
	logic [LVL_W-1:0] k;
	logic [CNT_W-1:0] win;

	logic [LVC_W-1:0] j_q;
	logic [POS_W-1:0] i_q;
	logic [POS_W-1:0] half;
	logic             issue, level_go;

	logic             valid_s1;
	logic [LVL_W-1:0] wr_lvl_s1;
	logic [POS_W-1:0] wr_idx_s1;

	logic             strobe_q;
	result_t          result_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign strobe    = strobe_q;
	assign result    = result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			count_q <= FIELD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[0];
				CFG_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective element count and range checks
	always_comb begin
		cnt_ext = CMP_W'(count_q);
		n_ext   = (cnt_ext > CMP_W'(MAX_ELEMENTS)) ? CMP_W'(MAX_ELEMENTS) : cnt_ext;
		pos_ext = CMP_W'(item.position);
		l_ext   = CMP_W'(item.left_bound);
		r_ext   = CMP_W'(item.right_bound);
		load_we = accept && (item.operation == OP_LOAD)
			&& (pos_ext != '0) && (pos_ext <= n_ext);
		bad_in  = (l_ext == '0) || (r_ext > n_ext) || (l_ext > r_ext);
	end

	// window level: leading one of the range length
	always_comb begin
		k = '0;
		for (int b = 0; b < CNT_W; b++) begin
			if (len_q[b]) begin
				k = (b > LEVEL_COUNT - 1) ? LVL_W'(LEVEL_COUNT - 1) : LVL_W'(b);
			end
		end
		win = CNT_W'(1) << k;
	end

	// build sequencer conditions
	always_comb begin
		half     = POS_W'(1) << (j_q - LVC_W'(1));
		issue    = (CMP_W'(i_q) + (CMP_W'(1) << j_q)) <= n_ext;
		level_go = (j_q < LVC_W'(LEVEL_COUNT)) && ((CMP_W'(1) << j_q) <= n_ext);
	end

	// read port and write port selection
	always_comb begin
		if (state_q == ST_BRUN) begin
			ra_lvl = LVL_W'(j_q - LVC_W'(1));
			rb_lvl = LVL_W'(j_q - LVC_W'(1));
			ra_idx = i_q;
			rb_idx = i_q + half;
		end else begin
			ra_lvl = k;
			rb_lvl = k;
			ra_idx = lm1_q;
			rb_idx = POS_W'(r_q - win);
		end
		if (valid_s1) begin
			wr_en   = 1'b1;
			wr_lvl  = wr_lvl_s1;
			wr_idx  = wr_idx_s1;
			wr_data = pick(mode_q, rd_a_q, rd_b_q);
		end else begin
			wr_en   = load_we;
			wr_lvl  = '0;
			wr_idx  = POS_W'(pos_ext - CMP_W'(1));
			wr_data = VALUE_W'(item.element_value);
		end
	end

	// level memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_lvl][wr_idx] <= wr_data;
		end
		rd_a_q <= mem[ra_lvl][ra_idx];
		rd_b_q <= mem[rb_lvl][rb_idx];
	end

	// query operands, no reset needed
	always_ff @(posedge clk) begin
		if (accept && (item.operation == OP_QUERY)) begin
			lm1_q <= POS_W'(l_ext - CMP_W'(1));
			r_q   <= CNT_W'(r_ext);
			len_q <= CNT_W'(r_ext - l_ext + CMP_W'(1));
		end
	end

	// sequencer, build pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bad_q     <= 1'b0;
			j_q       <= '0;
			i_q       <= '0;
			valid_s1  <= 1'b0;
			wr_lvl_s1 <= '0;
			wr_idx_s1 <= '0;
			strobe_q  <= 1'b0;
			result_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			valid_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.operation)
							OP_QUERY: begin
								bad_q   <= bad_in;
								state_q <= ST_QADDR;
							end
							OP_BUILD: begin
								j_q     <= LVC_W'(1);
								i_q     <= '0;
								state_q <= ST_BNEXT;
							end
							default: ;
						endcase
					end
				end
				ST_QADDR: begin
					if (bad_q) begin
						strobe_q        <= 1'b1;
						result_q.answer <= '0;
						result_q.status <= STATUS_BAD;
						state_q         <= ST_IDLE;
					end else begin
						state_q <= ST_QCMP;
					end
				end
				ST_QCMP: begin
					strobe_q        <= 1'b1;
					result_q.answer <= 32'(pick(mode_q, rd_a_q, rd_b_q));
					result_q.status <= STATUS_OK;
					state_q         <= ST_IDLE;
				end
				ST_BRUN: begin
					if (issue) begin
						valid_s1  <= 1'b1;
						wr_lvl_s1 <= LVL_W'(j_q);
						wr_idx_s1 <= i_q;
						i_q       <= i_q + POS_W'(1);
					end else begin
						// the idle beat lets the last write of this level land
						j_q     <= j_q + LVC_W'(1);
						i_q     <= '0;
						state_q <= ST_BNEXT;
					end
				end
				ST_BNEXT: begin
					if (level_go) begin
						state_q <= ST_BRUN;
					end else begin
						strobe_q        <= 1'b1;
						result_q.answer <= '0;
						result_q.status <= STATUS_BUILT;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`STRE_ASSERT_NOW(a_strobe_idle, strobe_q, state_q == ST_IDLE,
		"result strobe while sequencer busy")
	`STRE_ASSERT_NOW(a_no_write_clash, valid_s1, !load_we,
		"load write collides with build write")
	`STRE_ASSERT_NOW(a_build_level, valid_s1,
		(wr_lvl_s1 != '0) && (32'(wr_lvl_s1) < LEVEL_COUNT),
		"build writes outside the upper levels")
	`STRE_ASSERT_NEXT(a_issue_writes, (state_q == ST_BRUN) && issue, valid_s1,
		"issued build read gave no write")
	`STRE_ASSERT_NOW(a_zero_answer, strobe_q && (result_q.status != STATUS_OK),
		result_q.answer == '0, "non-query result carries an answer")

endmodule
